FILE: src/leb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and constants of the line edit buffer: operation codes,
// sequencer states and the packing widths of the stream words.
// ----------------------------------------------------------------------------
package leb_pkg;

   localparam int OP_W        = 3;
   localparam int CHAR_W      = 8;
   localparam int LEN_W       = 7;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT    = 3'd0,
      OP_BACKSPACE = 3'd1,
      OP_DELETE    = 3'd2,
      OP_LEFT      = 3'd3,
      OP_RIGHT     = 3'd4,
      OP_CLEAR     = 3'd5,
      OP_CONSUME   = 3'd6
   } leb_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_RESULT,
      ST_CON_RD,
      ST_CON_EMIT
   } leb_state_type;

endpackage : leb_pkg
`default_nettype wire

FILE: src/leb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// leb_ram
// Character store: one write port and one read port, read data registered.
// The read data register holds its value while no read is issued.
// ----------------------------------------------------------------------------
module leb_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : leb_ram
`default_nettype wire

FILE: src/line_edit_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_edit_buffer
// One-line text buffer with a cursor, driven by a stream of edit commands.
// ----------------------------------------------------------------------------
// The buffer holds up to CAPACITY characters in a single-port-pair RAM and
// answers every command word on req_ with one result word on rsp_, except
// consume, which returns the whole text as a run of words ending in tlast and
// empties the buffer when it is taken (an empty buffer gives one word with tuser low).
// Commands are taken one at a time. Left, right, clear, a refused edit and an
// unknown opcode go straight to the result. Insert, backspace and delete move
// the characters after the edit point one per cycle through the RAM before
// the result; consume reads the characters out one word each and is held back
// while the receiver stalls. A finished result waits in an output register,
// so the next command is accepted while it is still pending.
// ----------------------------------------------------------------------------
module line_edit_buffer #(
   parameter int CAPACITY = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [2:0] opcode, [10:3] char_in, [15:11] zero
   input  wire logic [leb_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [0] ok, [7:1] text_length, [14:8] cursor_out, [22:15] char_out, [23] zero
   output logic      [leb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [0] char_valid
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);

   import leb_pkg::*;

   // Count and cursor run from 0 to CAPACITY; RAM addresses below CAPACITY.
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   leb_state_type state_ff, state_in;

   // Edit state.
   logic [CW-1:0] count_ff,  count_in;
   logic [CW-1:0] cursor_ff, cursor_in;

   // Shift and consume sequencer. remain_ff counts reads still to issue during
   // a shift and holds the text length during consume.
   logic [AW-1:0] src_ff,    src_in;
   logic [AW-1:0] dst_ff,    dst_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic          pend_ff,   pend_in;
   logic          down_ff,   down_in;
   leb_op_type    op_ff,     op_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic          ok_ff,     ok_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff,    rsp_ok_in;
   logic [CW-1:0]          rsp_len_ff,   rsp_len_in;
   logic [CW-1:0]          rsp_cur_ff,   rsp_cur_in;
   logic [CHAR_W-1:0]      rsp_char_ff,  rsp_char_in;
   logic                   rsp_cv_ff,    rsp_cv_in;
   logic                   rsp_last_ff,  rsp_last_in;
   logic                   rsp_load;
   logic                   out_free;

   // RAM ports.
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [CHAR_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [CHAR_W-1:0] ram_rd_data;

   logic          accept;
   leb_op_type    req_op;
   logic [CHAR_W-1:0] req_char;
   logic          shift_done;
   logic [CW-1:0] idx_next;
   logic [CW+LEN_W-1:0] len_ext;
   logic [CW+LEN_W-1:0] cur_ext;

   assign req_op     = leb_op_type'(req_tdata[OP_W-1:0]);
   assign req_char   = req_tdata[OP_W+CHAR_W-1:OP_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign shift_done = (remain_ff == '0) && !pend_ff;
   assign idx_next   = CW'(src_ff) + CW'(1);

   leb_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW),
      .DW    (CHAR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_INSERT: begin
                     state_in = (count_ff < CW'(CAPACITY)) ? ST_SHIFT : ST_RESULT;
                  end
                  OP_BACKSPACE: begin
                     state_in = (cursor_ff != '0) ? ST_SHIFT : ST_RESULT;
                  end
                  OP_DELETE: begin
                     state_in = (cursor_ff < count_ff) ? ST_SHIFT : ST_RESULT;
                  end
                  OP_CONSUME: begin
                     state_in = (count_ff != '0) ? ST_CON_RD : ST_RESULT;
                  end
                  default: begin
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            if (shift_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CON_RD: begin
            state_in = ST_CON_EMIT;
         end
         ST_CON_EMIT: begin
            if (out_free && (idx_next == remain_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, RAM control and result loading.
   always_comb begin
      count_in    = count_ff;
      cursor_in   = cursor_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      remain_in   = remain_ff;
      pend_in     = pend_ff;
      down_in     = down_ff;
      op_in       = op_ff;
      ch_in       = ch_ff;
      ok_in       = ok_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = dst_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = src_ff;
      rsp_load    = 1'b0;
      rsp_ok_in   = ok_ff;
      rsp_len_in  = count_ff;
      rsp_cur_in  = cursor_ff;
      rsp_char_in = '0;
      rsp_cv_in   = 1'b0;
      rsp_last_in = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_op;
               ch_in   = req_char;
               pend_in = 1'b0;
               ok_in   = 1'b0;
               case (req_op)
                  OP_INSERT: begin
                     if (count_ff < CW'(CAPACITY)) begin
                        ok_in     = 1'b1;
                        src_in    = AW'(count_ff - CW'(1));
                        dst_in    = AW'(count_ff);
                        remain_in = count_ff - cursor_ff;
                        down_in   = 1'b1;
                     end
                  end
                  OP_BACKSPACE: begin
                     if (cursor_ff != '0) begin
                        ok_in     = 1'b1;
                        src_in    = AW'(cursor_ff);
                        dst_in    = AW'(cursor_ff - CW'(1));
                        remain_in = count_ff - cursor_ff;
                        down_in   = 1'b0;
                     end
                  end
                  OP_DELETE: begin
                     if (cursor_ff < count_ff) begin
                        ok_in     = 1'b1;
                        src_in    = AW'(cursor_ff + CW'(1));
                        dst_in    = AW'(cursor_ff);
                        remain_in = count_ff - cursor_ff - CW'(1);
                        down_in   = 1'b0;
                     end
                  end
                  OP_LEFT: begin
                     if (cursor_ff != '0) begin
                        ok_in     = 1'b1;
                        cursor_in = cursor_ff - CW'(1);
                     end
                  end
                  OP_RIGHT: begin
                     if (cursor_ff < count_ff) begin
                        ok_in     = 1'b1;
                        cursor_in = cursor_ff + CW'(1);
                     end
                  end
                  OP_CLEAR: begin
                     ok_in     = 1'b1;
                     count_in  = '0;
                     cursor_in = '0;
                  end
                  OP_CONSUME: begin
                     ok_in     = 1'b1;
                     remain_in = count_ff;
                     src_in    = '0;
                     count_in  = '0;
                     cursor_in = '0;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // A read issued last cycle is written one place over now; the
            // read and write addresses are never the same.
            if (pend_ff) begin
               ram_wr_en = 1'b1;
               dst_in    = down_ff ? (dst_ff - AW'(1)) : (dst_ff + AW'(1));
            end
            if (remain_ff != '0) begin
               ram_rd_en = 1'b1;
               src_in    = down_ff ? (src_ff - AW'(1)) : (src_ff + AW'(1));
               remain_in = remain_ff - CW'(1);
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (shift_done) begin
               case (op_ff)
                  OP_INSERT: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = AW'(cursor_ff);
                     ram_wr_data = ch_ff;
                     count_in    = count_ff + CW'(1);
                     cursor_in   = cursor_ff + CW'(1);
                  end
                  OP_BACKSPACE: begin
                     count_in  = count_ff - CW'(1);
                     cursor_in = cursor_ff - CW'(1);
                  end
                  default: begin
                     count_in = count_ff - CW'(1);
                  end
               endcase
            end
         end
         ST_RESULT: begin
            rsp_load = out_free;
         end
         ST_CON_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = src_ff;
         end
         ST_CON_EMIT: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_ok_in   = 1'b1;
               rsp_char_in = ram_rd_data;
               rsp_cv_in   = 1'b1;
               rsp_last_in = (idx_next == remain_ff);
               if (idx_next != remain_ff) begin
                  // Fetch the next character while this one goes out.
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = src_ff + AW'(1);
                  src_in      = src_ff + AW'(1);
               end
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      remain_ff <= remain_in;
      down_ff   <= down_in;
      op_ff     <= op_in;
      ch_ff     <= ch_in;
      ok_ff     <= ok_in;
      if (rsp_load) begin
         rsp_ok_ff   <= rsp_ok_in;
         rsp_len_ff  <= rsp_len_in;
         rsp_cur_ff  <= rsp_cur_in;
         rsp_char_ff <= rsp_char_in;
         rsp_cv_ff   <= rsp_cv_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   // Length and cursor leave the block as their low seven bits.
   assign len_ext = {{LEN_W{1'b0}}, rsp_len_ff};
   assign cur_ext = {{LEN_W{1'b0}}, rsp_cur_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff, cur_ext[LEN_W-1:0], len_ext[LEN_W-1:0], rsp_ok_ff};
   assign rsp_tuser  = rsp_cv_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule : line_edit_buffer
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the line edit buffer.
// ----------------------------------------------------------------------------
// Edit commands go in on the req_ stream. The testbench keeps its own copy of
// the text and the cursor. It updates that copy when a command word is
// accepted and queues the result words the command should produce. A checker
// process compares every word taken from the rsp_ stream, field by field,
// with the oldest queued result. The stimulus has four parts, run in turn:
// edge cases on a short line, a fill up to capacity, a long receiver stall
// that backs the block up, and random editing sessions. Both sides insert
// random gaps for most of the run.
// ----------------------------------------------------------------------------
module tb;
   import leb_pkg::*;

   localparam int CAPACITY         = 64;
   localparam int RANDOM_ITEMS     = 240;
   localparam int LONG_HOLD_CYCLES = 400;
   // This is longer than the slowest command (a shift of the whole line).
   localparam int SETTLE_CYCLES    = 100;
   localparam int CYCLE_LIMIT      = 4_000_000;
   localparam int REPORT_LIMIT     = 10;

   // Opcode 7 has no meaning. The block answers it with one refused result.
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   typedef struct {
      logic              ok;
      logic [LEN_W-1:0]  length;
      logic [LEN_W-1:0]  cursor;
      logic [CHAR_W-1:0] ch;
      logic              valid;
      logic              last;
   } edit_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [2:0] opcode, [10:3] char_in, [15:11] zero
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [0] ok, [7:1] text_length, [14:8] cursor_out, [22:15] char_out, [23] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // [0] char_valid
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   // This is our own copy of the editor state. It is updated when a word is accepted.
   logic [CHAR_W-1:0] shadow_text [CAPACITY];
   int unsigned       shadow_len    = 0;
   int unsigned       shadow_cursor = 0;
   edit_result_type   awaited_words [$];
   edit_result_type   seen_word;

   int unsigned mismatch_count = 0;
   int unsigned results_seen   = 0;
   int unsigned words_sent     = 0;
   int unsigned cycle_count    = 0;

   // These are the idle controls. The sender's control is used only by the main
   // process. The receiver's control is written with nonblocking assignments.
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   int unsigned hold_request = 0;
   int unsigned hold_taken   = 0;
   int unsigned hold_left    = 0;
   int unsigned stall_left   = 0;
   int unsigned rsp_gap;

   always #2 clock = ~clock;

   line_edit_buffer #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // Most gaps are zero or short. A small share are long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [CHAR_W-1:0] rand_char();
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // These are the cursor and deletion commands, which can fail at either end of the line.
   function automatic logic [OP_W-1:0] pick_edge_op();
      return OP_W'($urandom_range(OP_BACKSPACE, OP_RIGHT));
   endfunction

   function automatic logic [OP_W-1:0] pick_any_op();
      if ($urandom_range(0, 99) < 5) return OP_UNUSED;
      return OP_W'($urandom_range(OP_INSERT, OP_CONSUME));
   endfunction

   // A result word reports the state after the command.
   function automatic void await_word(input logic ok, input logic [CHAR_W-1:0] ch,
                                      input logic valid, input logic last);
      edit_result_type w;
      w.ok     = ok;
      w.length = shadow_len[LEN_W-1:0];
      w.cursor = shadow_cursor[LEN_W-1:0];
      w.ch     = ch;
      w.valid  = valid;
      w.last   = last;
      awaited_words.push_back(w);
   endfunction

   // This applies one command to the shadow line and queues the words it should cause.
   function automatic void apply_edit(input logic [OP_W-1:0] opcode,
                                      input logic [CHAR_W-1:0] ch);
      logic        ok;
      int unsigned i;
      int unsigned n;
      ok = 1'b0;
      case (opcode)
         OP_INSERT: begin
            // A full line refuses the character and stays unchanged.
            if (shadow_len < CAPACITY) begin
               for (i = shadow_len; i > shadow_cursor; i--)
                  shadow_text[i] = shadow_text[i-1];
               shadow_text[shadow_cursor] = ch;
               shadow_len++;
               shadow_cursor++;
               ok = 1'b1;
            end
         end
         OP_BACKSPACE: begin
            if (shadow_cursor > 0) begin
               for (i = shadow_cursor; i < shadow_len; i++)
                  shadow_text[i-1] = shadow_text[i];
               shadow_len--;
               shadow_cursor--;
               ok = 1'b1;
            end
         end
         OP_DELETE: begin
            if (shadow_cursor < shadow_len) begin
               for (i = shadow_cursor + 1; i < shadow_len; i++)
                  shadow_text[i-1] = shadow_text[i];
               shadow_len--;
               ok = 1'b1;
            end
         end
         OP_LEFT: begin
            if (shadow_cursor > 0) begin
               shadow_cursor--;
               ok = 1'b1;
            end
         end
         OP_RIGHT: begin
            if (shadow_cursor < shadow_len) begin
               shadow_cursor++;
               ok = 1'b1;
            end
         end
         OP_CLEAR: begin
            shadow_len    = 0;
            shadow_cursor = 0;
            ok            = 1'b1;
         end
         OP_CONSUME: begin
            // Every word of the run carries the emptied state. Only the final word has last set.
            n             = shadow_len;
            shadow_len    = 0;
            shadow_cursor = 0;
            if (n == 0)
               await_word(1'b1, '0, 1'b0, 1'b1);
            else
               for (i = 0; i < n; i++)
                  await_word(1'b1, shadow_text[i], 1'b1, i == n - 1);
            return;
         end
         default: ;
      endcase
      await_word(ok, '0, 1'b0, 1'b1);
   endfunction

   // This sends one command word. A valid that follows straight on stays high across words.
   task automatic send_word(input logic [OP_W-1:0] opcode, input logic [CHAR_W-1:0] ch);
      int unsigned gap;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - OP_W - CHAR_W){1'b0}}, ch, opcode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_edit(opcode, ch);
      if (opcode != OP_UNUSED) words_sent++;
   endtask

   // The sender stops until every queued result has come back, then lets the block settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // This part covers every opcode and both ends of the line. It uses the
   // lowest and highest characters and both ways of consuming a line.
   task automatic test_edge_cases();
      send_word(OP_BACKSPACE, 8'h00);   // backspace at the start of an empty line
      send_word(OP_LEFT, 8'hFF);        // left at the start
      send_word(OP_DELETE, 8'h00);      // delete at the end
      send_word(OP_RIGHT, 8'hFF);       // right at the end
      send_word(OP_CONSUME, 8'h00);     // consuming an empty line gives a single word
      send_word(OP_UNUSED, 8'hFF);
      send_word(OP_INSERT, 8'h00);
      send_word(OP_INSERT, 8'hFF);
      send_word(OP_INSERT, 8'hA5);
      send_word(OP_LEFT, 8'h00);
      send_word(OP_LEFT, 8'h00);
      send_word(OP_INSERT, 8'h5A);      // this insert goes in the middle and shifts the tail
      send_word(OP_RIGHT, 8'h00);
      send_word(OP_RIGHT, 8'h00);
      send_word(OP_RIGHT, 8'h00);       // this right is refused at the end
      send_word(OP_BACKSPACE, 8'h00);
      send_word(OP_LEFT, 8'h00);
      send_word(OP_DELETE, 8'h00);
      send_word(OP_DELETE, 8'h00);      // this delete is refused at the end
      send_word(OP_CONSUME, 8'h00);
      send_word(OP_INSERT, 8'h7E);
      send_word(OP_CLEAR, 8'hFF);
      send_word(OP_CONSUME, 8'h00);
      send_word(OP_INSERT, 8'h81);
      send_word(OP_CONSUME, 8'h00);
   endtask

   // This part fills the line to capacity with the cursor moving now and then.
   // It then hits every refusal at the full end and consumes the longest possible run.
   task automatic test_fill_to_capacity();
      int unsigned k;
      for (k = 0; k < CAPACITY; k++) begin
         if (k % 9 == 8) send_word(OP_LEFT, rand_char());
         send_word(OP_INSERT, rand_char());
      end
      send_word(OP_INSERT, rand_char());     // this insert is refused because the line is full
      while (shadow_cursor < shadow_len) send_word(OP_RIGHT, rand_char());
      send_word(OP_RIGHT, rand_char());
      send_word(OP_DELETE, rand_char());
      send_word(OP_INSERT, rand_char());
      send_word(OP_CONSUME, rand_char());
   endtask

   // The receiver holds off for a long stretch while commands keep coming.
   // The output register fills and the block has to stop taking commands.
   task automatic test_backpressure();
      int unsigned k;
      req_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      repeat (24) send_word(OP_INSERT, rand_char());
      drain_results();
      hold_request <= hold_request + 1;
      send_word(OP_CONSUME, rand_char());
      for (k = 0; k < 20; k++) begin
         if (k % 5 == 4) send_word(OP_LEFT, rand_char());
         send_word(OP_INSERT, rand_char());
      end
      send_word(OP_CONSUME, rand_char());
      drain_results();
      // The next hold runs with gaps on both sides.
      req_idle_on = 1'b1;
      rsp_idle_on <= 1'b1;
      hold_request <= hold_request + 1;
      repeat (12) send_word(OP_INSERT, rand_char());
      send_word(OP_BACKSPACE, rand_char());
      send_word(OP_CONSUME, rand_char());
      drain_results();
   endtask

   // This part runs typing sessions. Each types a line of random length with
   // some cursor edits mixed in, follows with a few random commands, and then
   // usually consumes or clears the line. Some sessions run past capacity.
   task automatic test_random_editing();
      int unsigned stop_at;
      int unsigned target;
      int unsigned extra;
      int unsigned r;
      int unsigned k;
      stop_at = words_sent + RANDOM_ITEMS;
      while (words_sent < stop_at) begin
         // Now and then a side runs with no gaps for a whole session.
         req_idle_on = ($urandom_range(0, 99) >= 15);
         rsp_idle_on <= ($urandom_range(0, 99) >= 15);
         r = $urandom_range(0, 9);
         if (r < 6)      target = $urandom_range(1, 12);
         else if (r < 9) target = $urandom_range(13, 40);
         else            target = CAPACITY + 2;
         for (k = 0; k < target; k++) begin
            if ($urandom_range(0, 99) < 25) send_word(pick_edge_op(), rand_char());
            send_word(OP_INSERT, rand_char());
         end
         extra = $urandom_range(0, 6);
         repeat (extra) send_word(pick_any_op(), rand_char());
         r = $urandom_range(0, 9);
         if (r < 7)      send_word(OP_CONSUME, rand_char());
         else if (r < 9) send_word(OP_CLEAR, rand_char());
      end
   endtask

   // The receiver draws random stalls. A change of hold_request starts a long
   // hold, and the receiver counts that hold down itself.
   always @(posedge clock) begin
      if (hold_request != hold_taken) begin
         hold_taken <= hold_request;
         hold_left  <= LONG_HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_idle_on) begin
         rsp_gap = pick_gap();
         rsp_tready <= (rsp_gap == 0);
         stall_left <= (rsp_gap == 0) ? 0 : rsp_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void flag_mismatch(input string field, input int unsigned want,
                                         input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch in %s at result word %0d: expected 0x%0h, got 0x%0h",
                  field, results_seen, want, got);
   endfunction

   // The checker compares every accepted result word with the oldest queued result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_words.size() == 0) begin
            flag_mismatch("unexpected word", 0, rsp_tdata);
         end else begin
            seen_word = awaited_words.pop_front();
            if (rsp_tdata[0] !== seen_word.ok)
               flag_mismatch("ok", seen_word.ok, rsp_tdata[0]);
            if (rsp_tdata[7:1] !== seen_word.length)
               flag_mismatch("text_length", seen_word.length, rsp_tdata[7:1]);
            if (rsp_tdata[14:8] !== seen_word.cursor)
               flag_mismatch("cursor_out", seen_word.cursor, rsp_tdata[14:8]);
            if (rsp_tdata[22:15] !== seen_word.ch)
               flag_mismatch("char_out", seen_word.ch, rsp_tdata[22:15]);
            if (rsp_tdata[23] !== 1'b0)
               flag_mismatch("tdata pad", 0, rsp_tdata[23]);
            if (rsp_tuser !== seen_word.valid)
               flag_mismatch("char_valid", seen_word.valid, rsp_tuser);
            if (rsp_tlast !== seen_word.last)
               flag_mismatch("last", seen_word.last, rsp_tlast);
         end
         results_seen++;
      end
   end

   // This watchdog ends the run at the cycle limit, in case the block stops making progress.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_cases();
      drain_results();
      test_fill_to_capacity();
      drain_results();
      test_backpressure();
      test_random_editing();
      drain_results();
      if (mismatch_count == 0 && awaited_words.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule : tb
